FILE: hdl/stepper_step_rate_generator_unit_defines.svh
// Assertion macros for the step rate generator.
`ifndef STEPPER_STEP_RATE_GENERATOR_UNIT_DEFINES_SVH
`define STEPPER_STEP_RATE_GENERATOR_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SSRG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SSRG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: hdl/ssrg_pkg.sv
// Shared types and constants of the step rate generator.
package ssrg_pkg;

    localparam int REQ_W     = 3;
    localparam int FREQ_W    = 15;
    localparam int CLK_W     = 27;
    localparam int CMP_W     = 16;
    localparam int PSC_W     = 7;
    localparam int PCNT_W    = 6;
    localparam int DEN_W     = FREQ_W + 7;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 32;

    typedef logic [REQ_W-1:0]  req_t;
    typedef logic [FREQ_W-1:0] freq_t;
    typedef logic [CMP_W-1:0]  cmp_t;
    typedef logic [PSC_W-1:0]  psc_t;

    localparam req_t REQ_TICK     = 3'd0;
    localparam req_t REQ_SET_FREQ = 3'd1;
    localparam req_t REQ_RUN      = 3'd2;
    localparam req_t REQ_STOP     = 3'd3;
    localparam req_t REQ_SET_DIR  = 3'd4;

    localparam logic CFG_CPU_CLOCK  = 1'b0;
    localparam logic CFG_LINEAR_FIT = 1'b1;

    localparam freq_t FREQ_FAST = 15'd1340;
    localparam freq_t FREQ_MID  = 15'd630;

    localparam psc_t PSC_OFF = 7'd0;
    localparam psc_t PSC_1   = 7'd1;
    localparam psc_t PSC_8   = 7'd8;
    localparam psc_t PSC_64  = 7'd64;

    localparam cmp_t       LIN_BASE    = 16'd6368;
    localparam logic [8:0] LIN_SLOPE   = 9'd305;
    localparam cmp_t       CMP_MAX     = 16'hFFFF;
    localparam logic [CLK_W-1:0] Q_SAT_LIMIT = 27'd65536;
    localparam logic [CLK_W-1:0] CLK_RESET   = 27'd16000000;

endpackage

FILE: hdl/stepper_step_rate_generator_unit.sv
// Top level of the step rate generator: request decode, CTC timer and restoring divider.
//
// Usage
//   Input channel s_*: one word per request. s_tuser carries the request kind
//   (tick, set frequency, run, stop, set direction); s_tdata carries the
//   frequency and the direction. Output channel m_*: one status word per
//   request, taken after the request is handled (step pin, direction pin,
//   running flag, compare value, prescaler).
//   For ticks, run, stop and set direction the status word shows up on m_*
//   the cycle after the request is taken, and a new request can be taken
//   every cycle while the receiver keeps m_tready high.
//   A set frequency that changes to a nonzero rate runs the restoring
//   divider, one bit of the quotient per cycle, then saturates and loads the
//   compare value (ST_SAT) and pulls back the timer (ST_FIN). With the linear
//   fit in use and a rate of at least FREQ_FAST the divider is skipped.
//   The input is not ready while the divider sequence runs.
//   When the receiver stalls, the status word holds on m_tdata and no new
//   request is taken until it is accepted.
//   Reset (aresetn low, synchronous) stops the timer, clears frequency,
//   prescaler, compare value and counts, sets the direction forward and
//   restores the configuration registers to their defaults.
module stepper_step_rate_generator_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_wr_en,
    input  logic                          cfg_addr,
    input  logic [ssrg_pkg::CLK_W-1:0]    cfg_wdata,
    // request channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [14:0] step_freq, [15] dir_forward
    input  logic [ssrg_pkg::S_DATA_W-1:0] s_tdata,
    // [2:0] req_type
    input  logic [ssrg_pkg::REQ_W-1:0]    s_tuser,
    // status channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] step_level, [1] dir_level, [2] is_running, [18:3] compare_value,
    // [25:19] prescale_sel, [31:26] zero
    output logic [ssrg_pkg::M_DATA_W-1:0] m_tdata
);
    import ssrg_pkg::*;

    `include "stepper_step_rate_generator_unit_defines.svh"

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    localparam logic [4:0] DIV_LAST = 5'(CLK_W - 1);

    // Control and architectural state
    logic [1:0]        state_reg, state_next;
    logic              m_valid_reg, m_valid_next;
    logic [CLK_W-1:0]  cpu_clock_reg, cpu_clock_next;
    logic              lin_fit_reg, lin_fit_next;
    logic              running_reg, running_next;
    freq_t             cur_freq_reg, cur_freq_next;
    psc_t              psc_reg, psc_next;
    cmp_t              cmp_reg, cmp_next;
    logic [PCNT_W-1:0] pcnt_reg, pcnt_next;
    cmp_t              timer_reg, timer_next;
    logic              step_reg, step_next;
    logic              dir_reg, dir_next;

    // Divider working registers
    logic [4:0]        step_cnt_reg, step_cnt_next;
    logic              lin_sel_reg, lin_sel_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [CLK_W-1:0]  quo_reg, quo_next;

    logic              s_accept;
    req_t              req;
    freq_t             in_freq;
    logic              in_dir;
    psc_t              psc_pick;
    logic [PSC_W-1:0]  pcnt_inc;
    logic [DEN_W+1:0]  trial;
    logic [23:0]       lin_prod;
    logic [13:0]       lin_sub;
    cmp_t              lin_cmp;
    cmp_t              div_cmp;

    assign req      = s_tuser;
    assign in_freq  = s_tdata[FREQ_W-1:0];
    assign in_dir   = s_tdata[FREQ_W];
    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, psc_reg, cmp_reg, running_reg, ~dir_reg, step_reg};

    // Prescaler choice for the incoming frequency
    always_comb begin
        if (in_freq >= FREQ_FAST) begin
            psc_pick = PSC_1;
        end else if (in_freq >= FREQ_MID) begin
            psc_pick = PSC_8;
        end else begin
            psc_pick = PSC_64;
        end
    end

    assign pcnt_inc = {1'b0, pcnt_reg} + 7'd1;

    // One restoring division step
    assign trial = {1'b0, rem_reg, quo_reg[CLK_W-1]} - {2'b00, den_reg};

    // Linear fit: 305/1024 approximates the slope
    assign lin_prod = LIN_SLOPE * cur_freq_reg;
    assign lin_sub  = lin_prod[23:10];
    assign lin_cmp  = ({2'b00, lin_sub} >= LIN_BASE) ? '0 : LIN_BASE - {2'b00, lin_sub};
    assign div_cmp  = ((quo_reg == '0) || (quo_reg > Q_SAT_LIMIT)) ? CMP_MAX
                    : quo_reg[CMP_W-1:0] - 16'd1;

    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg;
        cpu_clock_next = cpu_clock_reg;
        lin_fit_next  = lin_fit_reg;
        running_next  = running_reg;
        cur_freq_next = cur_freq_reg;
        psc_next      = psc_reg;
        cmp_next      = cmp_reg;
        pcnt_next     = pcnt_reg;
        timer_next    = timer_reg;
        step_next     = step_reg;
        dir_next      = dir_reg;
        step_cnt_next = step_cnt_reg;
        lin_sel_next  = lin_sel_reg;
        den_next      = den_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;

        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_CPU_CLOCK:  cpu_clock_next = cfg_wdata;
                CFG_LINEAR_FIT: lin_fit_next   = cfg_wdata[0];
                default: ;
            endcase
        end

        // Drop the status word once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    m_valid_next = 1'b1;
                    case (req)
                        REQ_TICK: begin
                            if (running_reg) begin
                                if (pcnt_inc >= psc_reg) begin
                                    pcnt_next = '0;
                                    if (timer_reg == cmp_reg) begin
                                        timer_next = '0;
                                        step_next  = ~step_reg;
                                    end else begin
                                        timer_next = timer_reg + 16'd1;
                                    end
                                end else begin
                                    pcnt_next = pcnt_inc[PCNT_W-1:0];
                                end
                            end
                        end
                        REQ_SET_FREQ: begin
                            if (in_freq != cur_freq_reg) begin
                                cur_freq_next = in_freq;
                                if (in_freq == '0) begin
                                    psc_next     = PSC_OFF;
                                    running_next = 1'b0;
                                end else begin
                                    psc_next     = psc_pick;
                                    m_valid_next = 1'b0;
                                    lin_sel_next = lin_fit_reg && (in_freq >= FREQ_FAST);
                                    rem_next     = '0;
                                    quo_next     = cpu_clock_reg;
                                    step_cnt_next = '0;
                                    case (psc_pick)
                                        PSC_1:   den_next = {6'd0, in_freq, 1'b0};
                                        PSC_8:   den_next = {3'd0, in_freq, 4'd0};
                                        default: den_next = {in_freq, 7'd0};
                                    endcase
                                    if (lin_fit_reg && (in_freq >= FREQ_FAST)) begin
                                        state_next = ST_SAT;
                                    end else begin
                                        state_next = ST_DIV;
                                    end
                                end
                            end
                        end
                        REQ_RUN: begin
                            if (cur_freq_reg == '0) begin
                                if (running_reg) begin
                                    step_next    = 1'b0;
                                    running_next = 1'b0;
                                end
                            end else if (!running_reg) begin
                                timer_next   = '0;
                                running_next = 1'b1;
                            end
                        end
                        REQ_STOP: begin
                            if (running_reg) begin
                                step_next    = 1'b0;
                                running_next = 1'b0;
                            end
                        end
                        REQ_SET_DIR: dir_next = in_dir;
                        default: ;
                    endcase
                end
            end
            ST_DIV: begin
                // Shift in one quotient bit per cycle
                if (!trial[DEN_W+1]) begin
                    rem_next = trial[DEN_W-1:0];
                end else begin
                    rem_next = {rem_reg[DEN_W-2:0], quo_reg[CLK_W-1]};
                end
                quo_next = {quo_reg[CLK_W-2:0], ~trial[DEN_W+1]};
                step_cnt_next = step_cnt_reg + 5'd1;
                if (step_cnt_reg == DIV_LAST) begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT: begin
                cmp_next   = lin_sel_reg ? lin_cmp : div_cmp;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // Pull the timer back by the new compare value if it has reached it
                if (timer_reg >= cmp_reg) begin
                    timer_next = timer_reg - cmp_reg;
                end
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            cpu_clock_reg <= CLK_RESET;
            lin_fit_reg   <= 1'b0;
            running_reg   <= 1'b0;
            cur_freq_reg  <= '0;
            psc_reg       <= PSC_OFF;
            cmp_reg       <= '0;
            pcnt_reg      <= '0;
            timer_reg     <= '0;
            step_reg      <= 1'b0;
            dir_reg       <= 1'b1;
            step_cnt_reg  <= '0;
            lin_sel_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            cpu_clock_reg <= cpu_clock_next;
            lin_fit_reg   <= lin_fit_next;
            running_reg   <= running_next;
            cur_freq_reg  <= cur_freq_next;
            psc_reg       <= psc_next;
            cmp_reg       <= cmp_next;
            pcnt_reg      <= pcnt_next;
            timer_reg     <= timer_next;
            step_reg      <= step_next;
            dir_reg       <= dir_next;
            step_cnt_reg  <= step_cnt_next;
            lin_sel_reg   <= lin_sel_next;
        end
    end

    always_ff @(posedge aclk) begin
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    // A running timer always has a prescaler armed
    `SSRG_ASSERT(a_run_has_psc, running_reg |-> (psc_reg != PSC_OFF), "running without prescaler")
    // No status word is offered while the divider works
    `SSRG_ASSERT_ALWAYS(a_div_quiet, (state_reg == ST_DIV) |-> !m_valid_reg, "status during divide")
    // Short requests answer on the next cycle
    `SSRG_ASSERT(a_short_resp, (s_accept && (req != REQ_SET_FREQ)) |=> m_valid_reg,
                 "short request gave no status word")
    // The divider only starts from a nonzero frequency
    `SSRG_ASSERT(a_div_freq, (state_reg == ST_DIV) |-> (cur_freq_reg != '0), "divide by zero rate")

endmodule

FILE: tb/stepper_step_rate_generator_unit_tb.sv
// Self-checking testbench for the step rate generator: directed script, then random phases.
`timescale 1ns / 1ps

module stepper_step_rate_generator_unit_tb;
    import ssrg_pkg::*;

    // Unused request codes: the block must leave its state alone for these.
    localparam req_t REQ_SPARE_5 = 3'd5;
    localparam req_t REQ_SPARE_6 = 3'd6;
    localparam req_t REQ_SPARE_7 = 3'd7;

    localparam int LIN_SHIFT     = 10;   // 305/1024 stands in for the 0.298 slope
    localparam int SETTLE_CYCLES = 40;   // longer than the divider sequence
    localparam int PHASE_ITEMS   = 104;
    localparam int PHASES        = 5;
    localparam int LONG_STALL    = 300;
    localparam int MAX_REPORTS   = 40;

    // One status word as it sits in m_tdata[25:0], highest field first.
    typedef struct packed {
        psc_t psc;
        cmp_t cmp;
        logic run;
        logic dir;
        logic step;
    } status_t;

    typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic             addr;
        logic [CLK_W-1:0] val;
        req_t             req;
        freq_t            freq;
        logic             fwd;
        logic             typed;
        status_t          exp;
    } row_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic                cfg_addr  = 1'b0;
    logic [CLK_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic [REQ_W-1:0]    s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // Motor state as the block should hold it, kept word by word.
    logic             running     = 1'b0;
    freq_t            cur_freq    = '0;
    psc_t             psc_div     = PSC_OFF;
    cmp_t             cmp_reg     = '0;
    logic [PCNT_W-1:0] psc_count  = '0;
    cmp_t             timer_count = '0;
    logic             step_pin    = 1'b0;
    logic             dir_flag    = 1'b1;
    logic [CLK_W-1:0] cpu_clock_hz = CLK_RESET;
    logic             linear_fit  = 1'b0;

    status_t pending_status[$];
    row_t    script[$];

    int  errors      = 0;
    int  n_words     = 0;
    int  n_checked   = 0;
    int  n_freq_sets = 0;
    int  n_toggles   = 0;
    bit  quiet_tail  = 1'b0;
    bit  stall_request = 1'b0;
    logic last_step  = 1'b0;

    stepper_step_rate_generator_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 aclk = ~aclk;

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("%0t: timeout, %0d status words still pending", $time, pending_status.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Stopping the timer drops the step pin; an idle timer is left alone.
    function automatic void halt_timer();
        if (running) begin
            step_pin = 1'b0;
            running  = 1'b0;
        end
    endfunction

    // Apply one request to the local motor state and return the status it leaves.
    function automatic status_t motor_status_after(req_t req, freq_t freq, logic fwd);
        longint unsigned den;
        longint unsigned quo;
        int unsigned     sub;
        case (req)
            REQ_TICK: begin
                if (running) begin
                    if (int'(psc_count) + 1 >= int'(psc_div)) begin
                        psc_count = '0;
                        if (timer_count == cmp_reg) begin
                            timer_count = '0;
                            step_pin    = ~step_pin;
                        end else begin
                            timer_count = timer_count + 16'd1;
                        end
                    end else begin
                        psc_count = psc_count + 6'd1;
                    end
                end
            end
            REQ_SET_FREQ: begin
                if (freq != cur_freq) begin
                    cur_freq = freq;
                    if (freq == '0) begin
                        psc_div = PSC_OFF;
                        running = 1'b0;
                    end else begin
                        if (freq >= FREQ_FAST)     psc_div = PSC_1;
                        else if (freq >= FREQ_MID) psc_div = PSC_8;
                        else                       psc_div = PSC_64;
                        if (linear_fit && freq >= FREQ_FAST) begin
                            sub = (int'(LIN_SLOPE) * int'(freq)) >> LIN_SHIFT;
                            cmp_reg = (sub >= 32'(LIN_BASE)) ? cmp_t'(0)
                                    : cmp_t'(32'(LIN_BASE) - sub);
                        end else begin
                            den = 64'(freq) * 64'(psc_div) * 64'd2;
                            quo = 64'(cpu_clock_hz) / den;
                            // a zero quotient wraps on the minus one and saturates
                            if (quo == 0 || quo - 1 > 64'(CMP_MAX)) cmp_reg = CMP_MAX;
                            else cmp_reg = cmp_t'(quo - 1);
                        end
                        // pull the count back by the new compare value if it has reached it
                        if (timer_count >= cmp_reg) timer_count = timer_count - cmp_reg;
                    end
                end
            end
            REQ_RUN: begin
                if (cur_freq == '0) begin
                    halt_timer();
                end else if (!running) begin
                    timer_count = '0;
                    running     = 1'b1;
                end
            end
            REQ_STOP:    halt_timer();
            REQ_SET_DIR: dir_flag = fwd;
            default: ;
        endcase
        return {psc_div, cmp_reg, running, ~dir_flag, step_pin};
    endfunction

    function automatic void plan_request(req_t req, freq_t freq, logic fwd);
        row_t row;
        row = '0;
        row.kind = ROW_REQ;
        row.req  = req;
        row.freq = freq;
        row.fwd  = fwd;
        script.push_back(row);
    endfunction

    // Row whose status is written out by hand.
    function automatic void plan_checked(req_t req, freq_t freq, logic fwd, status_t exp);
        row_t row;
        row = '0;
        row.kind  = ROW_REQ;
        row.req   = req;
        row.freq  = freq;
        row.fwd   = fwd;
        row.typed = 1'b1;
        row.exp   = exp;
        script.push_back(row);
    endfunction

    function automatic void plan_write(logic addr, logic [CLK_W-1:0] val);
        row_t row;
        row = '0;
        row.kind = ROW_CFG;
        row.addr = addr;
        row.val  = val;
        script.push_back(row);
    endfunction

    // Drop valid and hold until every pending status word has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0) @(posedge aclk);
    endtask

    // Write a register only once the block has gone quiet.
    task automatic write_register(input logic addr, input logic [CLK_W-1:0] val);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == CFG_CPU_CLOCK) cpu_clock_hz = val;
        else linear_fit = val[0];
    endtask

    // Offer one request word, wait for the handshake, then queue its status.
    task automatic send_request(input req_t req, input freq_t freq, input logic fwd,
                                input logic typed, input status_t typed_status);
        status_t predicted;
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {fwd, freq};
        do @(posedge aclk); while (!s_tready);
        predicted = motor_status_after(req, freq, fwd);
        pending_status.push_back(typed ? typed_status : predicted);
        n_words++;
        if (req == REQ_SET_FREQ) n_freq_sets++;
    endtask

    // Frequencies weighted toward the prescaler boundaries and the fast range.
    function automatic freq_t pick_freq();
        case ($urandom_range(0, 9))
            0: return '0;
            1: begin
                case ($urandom_range(0, 3))
                    0: return FREQ_MID - 15'd1;
                    1: return FREQ_MID;
                    2: return FREQ_FAST - 15'd1;
                    default: return FREQ_FAST;
                endcase
            end
            2, 3: return freq_t'($urandom_range(1, FREQ_MID - 1));
            4, 5: return freq_t'($urandom_range(FREQ_MID, FREQ_FAST - 1));
            6, 7, 8: return freq_t'($urandom_range(FREQ_FAST, 32767));
            default: return freq_t'($urandom_range(0, 32767));
        endcase
    endfunction

    function automatic req_t pick_request();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 62) return REQ_TICK;
        if (r < 72) return REQ_SET_FREQ;
        if (r < 82) return REQ_RUN;
        if (r < 88) return REQ_STOP;
        if (r < 95) return REQ_SET_DIR;
        case ($urandom_range(0, 2))
            0: return REQ_SPARE_5;
            1: return REQ_SPARE_6;
            default: return REQ_SPARE_7;
        endcase
    endfunction

    // Receiver: random bursts of backpressure, one long hold-off on request,
    // and a steady ready in the tail of the run.
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_request) begin
                stall_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Compare every accepted status word with the oldest one pending.
    always @(posedge aclk) begin : status_check
        status_t got;
        status_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = status_t'(m_tdata[25:0]);
            if (pending_status.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: status word %h with nothing pending, expected none",
                             $time, m_tdata);
            end else begin
                want = pending_status.pop_front();
                n_checked++;
                check_field("step_level",    32'(want.step), 32'(got.step));
                check_field("dir_level",     32'(want.dir),  32'(got.dir));
                check_field("is_running",    32'(want.run),  32'(got.run));
                check_field("compare_value", 32'(want.cmp),  32'(got.cmp));
                check_field("prescale_sel",  32'(want.psc),  32'(got.psc));
                check_field("pad bits",      0,              32'(m_tdata[M_DATA_W-1:26]));
            end
            if (got.step != last_step) n_toggles++;
            last_step = got.step;
        end
    end

    initial begin : stimulus
        row_t             row;
        logic [CLK_W-1:0] clk_val;
        logic             lin_val;
        req_t             req;

        // Reset state: idle, forward, nothing armed.
        plan_checked(REQ_TICK,     15'd0,     1'b0, {PSC_OFF, 16'd0, 1'b0, 1'b0, 1'b0});
        // run with no frequency acts as stop
        plan_checked(REQ_RUN,      15'd0,     1'b0, {PSC_OFF, 16'd0, 1'b0, 1'b0, 1'b0});
        plan_checked(REQ_STOP,     15'd0,     1'b1, {PSC_OFF, 16'd0, 1'b0, 1'b0, 1'b0});
        plan_checked(REQ_SET_DIR,  15'd0,     1'b0, {PSC_OFF, 16'd0, 1'b0, 1'b1, 1'b0});
        plan_checked(REQ_SET_DIR,  15'h7FFF,  1'b1, {PSC_OFF, 16'd0, 1'b0, 1'b0, 1'b0});
        // same frequency as now: no change
        plan_checked(REQ_SET_FREQ, 15'd0,     1'b1, {PSC_OFF, 16'd0, 1'b0, 1'b0, 1'b0});
        plan_checked(REQ_SET_FREQ, 15'h7FFF,  1'b0, {PSC_1, 16'd243, 1'b0, 1'b0, 1'b0});
        // slowest rate saturates the compare value
        plan_checked(REQ_SET_FREQ, 15'd1,     1'b0, {PSC_64, CMP_MAX, 1'b0, 1'b0, 1'b0});
        plan_request(REQ_SET_FREQ, FREQ_MID - 15'd1,  1'b0);
        plan_request(REQ_SET_FREQ, FREQ_MID,          1'b1);
        plan_request(REQ_SET_FREQ, FREQ_FAST - 15'd1, 1'b0);
        plan_request(REQ_SET_FREQ, FREQ_FAST,         1'b1);
        plan_request(REQ_RUN,      15'd0,     1'b0);
        plan_request(REQ_RUN,      15'd0,     1'b0);
        plan_request(REQ_TICK,     15'h7FFF,  1'b1);
        plan_request(REQ_TICK,     15'd0,     1'b0);
        plan_request(REQ_SPARE_5,  15'h7FFF,  1'b1);
        plan_request(REQ_SPARE_6,  15'd7,     1'b0);
        plan_request(REQ_SPARE_7,  15'd3000,  1'b1);
        // zero frequency while running disarms and stops
        plan_request(REQ_SET_FREQ, 15'd0,     1'b0);
        plan_request(REQ_RUN,      15'd0,     1'b0);
        // linear fit: the top rate clamps the compare value at zero
        plan_write(CFG_LINEAR_FIT, 27'd1);
        plan_checked(REQ_SET_FREQ, 15'h7FFF,  1'b0, {PSC_1, 16'd0, 1'b0, 1'b0, 1'b0});
        plan_request(REQ_RUN,      15'd0,     1'b0);
        plan_request(REQ_TICK,     15'd0,     1'b0);
        plan_request(REQ_TICK,     15'd0,     1'b0);
        plan_request(REQ_TICK,     15'd0,     1'b0);
        plan_request(REQ_SET_FREQ, FREQ_FAST, 1'b0);
        plan_request(REQ_STOP,     15'd0,     1'b0);
        // slowest clock: the quotient is zero and the value saturates
        plan_write(CFG_LINEAR_FIT, 27'd0);
        plan_write(CFG_CPU_CLOCK,  27'd1);
        plan_checked(REQ_SET_FREQ, 15'd1000,  1'b0, {PSC_8, CMP_MAX, 1'b0, 1'b0, 1'b0});
        plan_write(CFG_CPU_CLOCK,  27'd100000000);
        plan_checked(REQ_SET_FREQ, 15'd1,     1'b0, {PSC_64, CMP_MAX, 1'b0, 1'b0, 1'b0});

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed script.
        for (int i = 0; i < script.size(); i++) begin
            row = script[i];
            if (row.kind == ROW_CFG) write_register(row.addr, row.val);
            else send_request(row.req, row.freq, row.fwd, row.typed, row.exp);
        end

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    clk_val = CLK_W'($urandom_range(20000, 400000));
                    lin_val = 1'b0;
                end
                1: begin
                    clk_val = 27'd100000000;
                    lin_val = 1'b1;
                end
                2: begin
                    clk_val = CLK_W'($urandom_range(1, 5000));
                    lin_val = 1'($urandom_range(0, 1));
                end
                3: begin
                    clk_val = CLK_RESET;
                    lin_val = 1'b0;
                end
                default: begin
                    clk_val = CLK_W'($urandom_range(20000, 400000));
                    lin_val = 1'b1;
                end
            endcase
            write_register(CFG_CPU_CLOCK,  clk_val);
            write_register(CFG_LINEAR_FIT, {{(CLK_W-1){1'b0}}, lin_val});

            // arm a rate and start the timer so the ticks have work to do
            send_request(REQ_SET_FREQ, freq_t'($urandom_range(1, 32767)),
                         1'($urandom_range(0, 1)), 1'b0, '0);
            send_request(REQ_RUN, pick_freq(), 1'($urandom_range(0, 1)), 1'b0, '0);

            for (int n = 2; n < PHASE_ITEMS; n++) begin
                if (ph == PHASES - 1 && n >= 20) quiet_tail = 1'b1;
                // long receiver hold-off while requests keep coming
                if (ph == 1 && n == 20) stall_request = 1'b1;
                // let everything in flight come back before going on
                if (ph == 2 && n == 50) drain_results();
                req = pick_request();
                send_request(req, pick_freq(), 1'($urandom_range(0, 1)), 1'b0, '0);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Run covered %0d request words (%0d rate changes), %0d status words checked,",
                 n_words, n_freq_sets, n_checked);
        $display("%0d step pin edges seen across %0d register settings, %0d mismatches",
                 n_toggles, PHASES + 3, errors);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
